[rtl/chacha_pkg.sv]
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types and constants of the byte-wide ChaCha20 stream cipher: word
// type, key material bundle, core request and status groups, register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package chacha_pkg;

  // number of double rounds per keystream block
  localparam int DOUBLE_ROUNDS = 10;
  localparam int RND_W         = $clog2(DOUBLE_ROUNDS);

  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  typedef logic [WORD_W-1:0] word_t;

  // "expand 32-byte k"
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW         = 3'd0,
    REG_KEY_MID_LOW     = 3'd1,
    REG_KEY_MID_HIGH    = 3'd2,
    REG_KEY_HIGH        = 3'd3,
    REG_NONCE_LOW       = 3'd4,
    REG_NONCE_HIGH      = 3'd5,
    REG_INITIAL_COUNTER = 3'd6
  } cfg_reg_t;

  // key and nonce as little-endian words
  typedef struct packed {
    logic [7:0][WORD_W-1:0] key_w;
    logic [2:0][WORD_W-1:0] nonce_w;
  } chacha_key_t;

  // block request towards the core
  typedef struct packed {
    logic  start;
    word_t counter;
  } chacha_req_t;

  // core status back to the controller
  typedef struct packed {
    logic busy;
    logic done;
  } chacha_status_t;

endpackage

`default_nettype wire

[rtl/chacha_core.sv]
// ----------------------------------------------------------------------------
// chacha_core
// Keystream block generator: one round unit doing one quarter-round step on
// all four columns or diagonals per cycle, then the feed-forward add.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha_core (
  input  logic                     clk,
  input  logic                     rst,
  input  chacha_pkg::chacha_key_t  key_in,
  input  chacha_pkg::chacha_req_t  req,
  output chacha_pkg::chacha_status_t status,
  output chacha_pkg::word_t        ks_words [chacha_pkg::NUM_WORDS]
);
  import chacha_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} core_state_t;

  core_state_t      state;
  logic [1:0]       step;
  logic             diag;
  logic [RND_W-1:0] round;
  logic             done;
  word_t            ctr;
  word_t            work      [4][4];
  word_t            work_next [4][4];
  logic [NUM_WORDS-1:0][WORD_W-1:0] init_run;
  logic [NUM_WORDS-1:0][WORD_W-1:0] init_start;

  // initial state for a given block counter
  function automatic logic [NUM_WORDS-1:0][WORD_W-1:0] make_init(
    input chacha_key_t k,
    input word_t       c
  );
    logic [NUM_WORDS-1:0][WORD_W-1:0] s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      s[4+i] = k.key_w[i];
    end
    s[12] = c;
    for (int i = 0; i < 3; i++) begin
      s[13+i] = k.nonce_w[i];
    end
    return s;
  endfunction

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

  assign init_run   = make_init(key_in, ctr);
  assign init_start = make_init(key_in, req.counter);

  // round unit: one quarter-round step on four independent lanes
  always_comb begin
    logic [1:0]  bi, ci, di;
    logic [4:0]  amt;
    word_t       a, b, c, d, sum, mix;
    work_next = work;
    unique case (step)
      2'd0:    amt = 5'd16;
      2'd1:    amt = 5'd12;
      2'd2:    amt = 5'd8;
      default: amt = 5'd7;
    endcase
    for (int i = 0; i < 4; i++) begin
      bi = diag ? 2'(i + 1) : 2'(i);
      ci = diag ? 2'(i + 2) : 2'(i);
      di = diag ? 2'(i + 3) : 2'(i);
      a  = work[0][i];
      b  = work[1][bi];
      c  = work[2][ci];
      d  = work[3][di];
      if (!step[0]) begin
        sum = a + b;
        mix = rotl(d ^ sum, amt);
        work_next[0][i]  = sum;
        work_next[3][di] = mix;
      end else begin
        sum = c + d;
        mix = rotl(b ^ sum, amt);
        work_next[2][ci] = sum;
        work_next[1][bi] = mix;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step  <= '0;
      diag  <= 1'b0;
      round <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            ctr   <= req.counter;
            step  <= '0;
            diag  <= 1'b0;
            round <= '0;
            for (int r = 0; r < 4; r++) begin
              for (int c = 0; c < 4; c++) begin
                work[r][c] <= init_start[r*4+c];
              end
            end
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          work <= work_next;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            diag <= !diag;
            if (diag) begin
              round <= round + 1'b1;
              if (round == RND_W'(DOUBLE_ROUNDS - 1)) begin
                state <= C_FINAL;
              end
            end
          end
        end
        C_FINAL: begin
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
              ks_words[r*4+c] <= work[r][c] + init_run[r*4+c];
            end
          end
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign status.busy = (state != C_IDLE);
  assign status.done = done;

  // start only reaches an idle core
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == C_IDLE)
    else $error("block request while core busy");

  // done follows the feed-forward cycle
  a_done_after_final: assert property (@(posedge clk) disable iff (rst)
    (state == C_FINAL) |=> done && state == C_IDLE)
    else $error("feed-forward not followed by done");

  // round counter stays in range
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == C_ROUND |-> round <= RND_W'(DOUBLE_ROUNDS - 1))
    else $error("round counter out of range");

endmodule

`default_nettype wire

[rtl/chacha20_stream_cipher_top.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// Byte-wide ChaCha20 (RFC 8439 layout) encrypt/decrypt: each input word is
// XORed with the next keystream byte; keystream is made one block at a time.
//
//   channel  signals                          dir  meaning
//   in       in_valid in_stall data_byte last  in   message bytes
//   result   result_valid result_stall        out  XORed bytes, last copied
//            result_byte result_last
//   cfg      cfg_write cfg_index cfg_data      in   key, nonce, counter regs
//
// A byte inside a keystream block is XORed straight into the result
// register when it can take one. A byte at block offset zero waits for the
// round unit to run DOUBLE_ROUNDS double rounds and the feed-forward add.
// Synchronous reset clears all control state and config; no clearing pass.
// The result register lets a new word be taken in the cycle its predecessor
// leaves; in_stall is high while the core runs.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_cipher_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              last,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [7:0]                        result_byte,
  output logic                              result_last,
  input  logic                              cfg_write,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data
);
  import chacha_pkg::*;

  typedef enum logic {ST_IDLE, ST_GEN} top_state_t;

  top_state_t     state;
  logic [63:0]    key_low, key_mid_low, key_mid_high, key_high, nonce_low;
  word_t          nonce_high, initial_counter;
  word_t          block_counter;
  logic [5:0]     byte_offset;
  logic           message_start;
  logic [7:0]     held_byte;
  logic           held_last;

  chacha_key_t    key_bundle;
  chacha_req_t    req;
  chacha_status_t status;
  word_t          ks_words [NUM_WORDS];

  logic           accept;
  logic [5:0]     eff_offset;
  word_t          ctr_eff;
  word_t          sel_word;
  logic [7:0]     ks_byte;
  logic           result_load;

  // key material in little-endian words
  assign key_bundle.key_w[0]   = key_low[31:0];
  assign key_bundle.key_w[1]   = key_low[63:32];
  assign key_bundle.key_w[2]   = key_mid_low[31:0];
  assign key_bundle.key_w[3]   = key_mid_low[63:32];
  assign key_bundle.key_w[4]   = key_mid_high[31:0];
  assign key_bundle.key_w[5]   = key_mid_high[63:32];
  assign key_bundle.key_w[6]   = key_high[31:0];
  assign key_bundle.key_w[7]   = key_high[63:32];
  assign key_bundle.nonce_w[0] = nonce_low[31:0];
  assign key_bundle.nonce_w[1] = nonce_low[63:32];
  assign key_bundle.nonce_w[2] = nonce_high;

  // handshake and block position
  assign in_stall   = (state != ST_IDLE) || (result_valid && result_stall);
  assign accept     = in_valid && !in_stall;
  assign eff_offset = message_start ? 6'd0 : byte_offset;
  assign ctr_eff    = message_start ? initial_counter : block_counter;

  // keystream byte picked by offset
  assign sel_word = ks_words[eff_offset[5:2]];
  assign ks_byte  = sel_word[{eff_offset[1:0], 3'b000} +: 8];

  assign req.start   = accept && (eff_offset == 6'd0);
  assign req.counter = ctr_eff;

  // result register gets a new word
  assign result_load = (state == ST_IDLE && accept && eff_offset != 6'd0) ||
                       (state == ST_GEN && status.done);

  chacha_core u_core (
    .clk      (clk),
    .rst      (rst),
    .key_in   (key_bundle),
    .req      (req),
    .status   (status),
    .ks_words (ks_words)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low         <= '0;
      key_mid_low     <= '0;
      key_mid_high    <= '0;
      key_high        <= '0;
      nonce_low       <= '0;
      nonce_high      <= '0;
      initial_counter <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_LOW:         key_low         <= cfg_data;
        REG_KEY_MID_LOW:     key_mid_low     <= cfg_data;
        REG_KEY_MID_HIGH:    key_mid_high    <= cfg_data;
        REG_KEY_HIGH:        key_high        <= cfg_data;
        REG_NONCE_LOW:       nonce_low       <= cfg_data;
        REG_NONCE_HIGH:      nonce_high      <= cfg_data[WORD_W-1:0];
        REG_INITIAL_COUNTER: initial_counter <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // controller and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      block_counter <= '0;
      byte_offset   <= '0;
      message_start <= 1'b1;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            message_start <= last;
            byte_offset   <= eff_offset + 6'd1;
            if (eff_offset == 6'd0) begin
              block_counter <= ctr_eff + 32'd1;
              held_byte     <= data_byte;
              held_last     <= last;
              state         <= ST_GEN;
            end else begin
              result_byte  <= data_byte ^ ks_byte;
              result_last  <= last;
            end
          end
        end
        ST_GEN: begin
          if (status.done) begin
            result_byte  <= held_byte ^ ks_words[0][7:0];
            result_last  <= held_last;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a word is only taken when the result register can receive it
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(result_valid && result_stall))
    else $error("input taken while result blocked");

  // core completion only arrives while waiting for a block
  a_done_in_gen: assert property (@(posedge clk) disable iff (rst)
    status.done |-> state == ST_GEN)
    else $error("unexpected block completion");

  // waiting for a block implies a busy or finishing core
  a_gen_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_GEN |-> status.busy || status.done)
    else $error("waiting on an idle core");

  // block start always leaves the controller waiting
  a_start_gen: assert property (@(posedge clk) disable iff (rst)
    req.start |=> state == ST_GEN && !result_valid)
    else $error("block start not followed by wait");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-wide ChaCha20 stream cipher. Messages of
// random bytes are pushed through the input channel while a software copy of
// the cipher predicts every XORed byte; each result word is compared field by
// field with the oldest prediction. Key, nonce and initial counter are
// reprogrammed between bursts, sometimes in the middle of a message.
// ----------------------------------------------------------------------------

module tb_top;
  import chacha_pkg::*;

  localparam int RANDOM_ITEMS  = 900;
  // round unit latency plus margin, used before config writes and at the end
  localparam int SETTLE_CYCLES = 8 * chacha_pkg::DOUBLE_ROUNDS + 40;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 3'd7;

  // "expand 32-byte k"
  localparam word_t EXPAND_0 = 32'h6170_7865;
  localparam word_t EXPAND_1 = 32'h3320_646e;
  localparam word_t EXPAND_2 = 32'h7962_2d32;
  localparam word_t EXPAND_3 = 32'h6b20_6574;

  typedef logic [15:0][31:0] ks_block_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } msg_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  last = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [7:0]            result_byte;
  logic                  result_last;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  chacha20_stream_cipher_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_byte  (result_byte),
    .result_last  (result_last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the cipher registers and stream position
  logic [63:0] key_low_r = '0, key_mid_low_r = '0, key_mid_high_r = '0, key_high_r = '0;
  logic [63:0] nonce_low_r = '0;
  word_t       nonce_high_r = '0;
  word_t       start_counter_r = '0;
  word_t       block_ctr = '0;
  logic [5:0]  stream_pos = '0;
  logic        msg_start = 1'b1;
  ks_block_t   keystream = '0;

  msg_word_t plain_queue[$];
  msg_word_t cipher_queue[$];
  msg_word_t next_word;
  msg_word_t want;
  bit        in_fire = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        errors = 0;
  int        random_sent = 0;

  function automatic word_t rotl32(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic ks_block_t quarter_round(ks_block_t x, int a, int b, int c, int d);
    x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 7);
    return x;
  endfunction

  // one 64-byte keystream block from the shadow key and nonce
  function automatic ks_block_t chacha_block(word_t ctr);
    ks_block_t init_st;
    ks_block_t work;
    init_st[0]  = EXPAND_0;
    init_st[1]  = EXPAND_1;
    init_st[2]  = EXPAND_2;
    init_st[3]  = EXPAND_3;
    init_st[4]  = key_low_r[31:0];
    init_st[5]  = key_low_r[63:32];
    init_st[6]  = key_mid_low_r[31:0];
    init_st[7]  = key_mid_low_r[63:32];
    init_st[8]  = key_mid_high_r[31:0];
    init_st[9]  = key_mid_high_r[63:32];
    init_st[10] = key_high_r[31:0];
    init_st[11] = key_high_r[63:32];
    init_st[12] = ctr;
    init_st[13] = nonce_low_r[31:0];
    init_st[14] = nonce_low_r[63:32];
    init_st[15] = nonce_high_r;
    work = init_st;
    for (int i = 0; i < chacha_pkg::DOUBLE_ROUNDS; i++) begin
      work = quarter_round(work, 0, 4, 8, 12);
      work = quarter_round(work, 1, 5, 9, 13);
      work = quarter_round(work, 2, 6, 10, 14);
      work = quarter_round(work, 3, 7, 11, 15);
      work = quarter_round(work, 0, 5, 10, 15);
      work = quarter_round(work, 1, 6, 11, 12);
      work = quarter_round(work, 2, 7, 8, 13);
      work = quarter_round(work, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++)
      work[i] = work[i] + init_st[i];
    return work;
  endfunction

  // advance the shadow stream by one accepted word and queue its cipher byte
  function automatic void predict_cipher_word(logic [7:0] value, logic is_last);
    word_t     ks_word;
    msg_word_t res;
    if (msg_start) begin
      block_ctr  = start_counter_r;
      stream_pos = '0;
    end
    if (stream_pos == 6'd0) begin
      keystream = chacha_block(block_ctr);
      block_ctr = block_ctr + 32'd1;
    end
    ks_word     = keystream[stream_pos[5:2]] >> {stream_pos[1:0], 3'b000};
    stream_pos  = stream_pos + 6'd1;
    msg_start   = is_last;
    res.value   = value ^ ks_word[7:0];
    res.is_last = is_last;
    cipher_queue.push_back(res);
  endfunction

  // register write, mirrored into the shadow copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_KEY_LOW:         key_low_r = value;
      REG_KEY_MID_LOW:     key_mid_low_r = value;
      REG_KEY_MID_HIGH:    key_mid_high_r = value;
      REG_KEY_HIGH:        key_high_r = value;
      REG_NONCE_LOW:       nonce_low_r = value;
      REG_NONCE_HIGH:      nonce_high_r = value[31:0];
      REG_INITIAL_COUNTER: start_counter_r = value[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_word(logic [7:0] value, logic is_last);
    msg_word_t w;
    w.value   = value;
    w.is_last = is_last;
    plain_queue.push_back(w);
  endtask

  task automatic queue_message(int len, bit close);
    @(posedge clk);
    for (int i = 0; i < len; i++)
      queue_word(8'($urandom_range(255)), close && (i == len - 1));
  endtask

  // everything sent and answered, then let the round unit settle
  task automatic wait_idle();
    while (plain_queue.size() != 0 || in_valid || cipher_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(3))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // counter values, often near the wrap, with junk above bit 31
  function automatic logic [63:0] pick_counter();
    case ($urandom_range(4))
      0:       return {$urandom, 32'hFFFF_FFFF};
      1:       return {$urandom, 32'hFFFF_FFFE};
      2:       return {$urandom, 32'h0};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (plain_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = plain_queue.pop_front();
        in_valid  <= 1'b1;
        data_byte <= next_word.value;
        last      <= next_word.is_last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire)
      predict_cipher_word(data_byte, last);
    if (!rst && result_valid && !result_stall) begin
      if (cipher_queue.size() == 0) begin
        $display("%0t: unexpected result word, byte %h last %b",
                 $time, result_byte, result_last);
        errors++;
      end else begin
        want = cipher_queue.pop_front();
        if (result_byte !== want.value) begin
          $display("%0t: result_byte expected %h actual %h", $time, want.value, result_byte);
          errors++;
        end
        if (result_last !== want.is_last) begin
          $display("%0t: result_last expected %b actual %b",
                   $time, want.is_last, result_last);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int  seg_msgs;
    int  len;
    int  r;
    bit  close;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 26;
    recv_idle_pct = 63;

    // all-zero key and nonce straight after reset
    @(posedge clk);
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b1);
    wait_idle();

    // standard test vector key and nonce, junk above the nonce_high width
    write_reg(REG_KEY_LOW,         64'h0706_0504_0302_0100);
    write_reg(REG_KEY_MID_LOW,     64'h0f0e_0d0c_0b0a_0908);
    write_reg(REG_KEY_MID_HIGH,    64'h1716_1514_1312_1110);
    write_reg(REG_KEY_HIGH,        64'h1f1e_1d1c_1b1a_1918);
    write_reg(REG_NONCE_LOW,       64'h4a00_0000_0000_0000);
    write_reg(REG_NONCE_HIGH,      64'hDEAD_BEEF_0000_0000);
    write_reg(REG_INITIAL_COUNTER, 64'h1);
    @(posedge clk);
    queue_word(8'h4c, 1'b0);
    queue_word(8'h61, 1'b0);
    queue_word(8'h64, 1'b0);
    queue_word(8'h69, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h00, 1'b1);
    wait_idle();

    // write to an unused index is ignored
    write_reg(UNUSED_REG_INDEX, '1);
    @(posedge clk);
    queue_word(8'hA5, 1'b1);
    queue_word(8'h5A, 1'b1);
    wait_idle();

    // all ones everywhere, counter at its maximum
    write_reg(REG_KEY_LOW,         '1);
    write_reg(REG_KEY_MID_LOW,     '1);
    write_reg(REG_KEY_MID_HIGH,    '1);
    write_reg(REG_KEY_HIGH,        '1);
    write_reg(REG_NONCE_LOW,       '1);
    write_reg(REG_NONCE_HIGH,      '1);
    write_reg(REG_INITIAL_COUNTER, '1);
    @(posedge clk);
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h3C, 1'b1);
    wait_idle();

    // config change inside an open message: current block kept
    @(posedge clk);
    queue_word(8'h12, 1'b0);
    queue_word(8'h34, 1'b0);
    wait_idle();
    write_reg(REG_KEY_LOW, 64'h0);
    write_reg(REG_INITIAL_COUNTER, 64'h5);
    @(posedge clk);
    queue_word(8'h56, 1'b1);
    queue_word(8'h78, 1'b1);
    wait_idle();

    // counter wrap across block boundaries
    write_reg(REG_INITIAL_COUNTER, {$urandom, 32'hFFFF_FFFF});
    queue_message(100, 1'b1);
    random_sent = 100;

    // random bursts of messages, the last one sometimes left open
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 63;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(1)) write_reg(REG_KEY_LOW, pick_value());
      if ($urandom_range(1)) write_reg(REG_KEY_MID_LOW, pick_value());
      if ($urandom_range(1)) write_reg(REG_KEY_MID_HIGH, pick_value());
      if ($urandom_range(1)) write_reg(REG_KEY_HIGH, pick_value());
      if ($urandom_range(1)) write_reg(REG_NONCE_LOW, pick_value());
      if ($urandom_range(1)) write_reg(REG_NONCE_HIGH, pick_value());
      if ($urandom_range(1)) write_reg(REG_INITIAL_COUNTER, pick_counter());
      if ($urandom_range(3) == 0) write_reg(UNUSED_REG_INDEX, pick_value());
      seg_msgs = $urandom_range(1, 4);
      for (int m = 0; m < seg_msgs; m++) begin
        r = $urandom_range(99);
        if (r < 70)
          len = $urandom_range(1, 16);
        else if (r < 90)
          len = $urandom_range(17, 80);
        else
          len = $urandom_range(81, 150);
        close = !((m == seg_msgs - 1) && ($urandom_range(3) == 0));
        queue_message(len, close);
        random_sent += len;
      end
    end

    wait_idle();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/chacha_pkg.sv
rtl/chacha_core.sv
rtl/chacha20_stream_cipher_top.sv
bench/tb_top.sv
